// ===== rtl/usb_pkg.sv =====
// package for the ultrametric simplex builder: sizes, codes, states and helpers
`timescale 1ns / 1ps

package usb_pkg;

    localparam int MAX_DIM  = 16;
    localparam int MAX_COLS = 16;
    localparam int DIM_W    = 5;
    localparam int CNT_W    = $clog2(MAX_COLS + 1);
    localparam int COL_AW   = $clog2(MAX_COLS);
    localparam int DIGIT_W  = 4;
    localparam int DIGITS   = MAX_DIM / DIGIT_W;
    localparam int DIGIT_CW = $clog2(DIGITS);
    localparam int GRAM_W   = $clog2(MAX_DIM + 1);
    localparam int PC_W     = $clog2(DIGIT_W + 1);

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_CHECK  = 2'd1;
    localparam logic [1:0] CMD_APPEND = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_ACC,
        S_EVAL,
        S_ROWS
    } state_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = d;
        return r;
    endfunction

    function automatic logic [MAX_DIM-1:0] dim_mask(input logic [DIM_W-1:0] d);
        logic [MAX_DIM-1:0] m;
        logic [DIM_W-1:0]   e;
        e = eff_dim(d);
        for (int k = 0; k < MAX_DIM; k++)
        begin
            m[k] = (k < e);
        end
        return m;
    endfunction

    function automatic logic [PC_W-1:0] popcount_digit(input logic [DIGIT_W-1:0] x);
        logic [PC_W-1:0] c;
        c = '0;
        for (int k = 0; k < DIGIT_W; k++)
        begin
            c = c + PC_W'(x[k]);
        end
        return c;
    endfunction

endpackage

// ===== rtl/usb_ram.sv =====
// generic ram with one write port and two registered read ports
`timescale 1ns / 1ps

module usb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/ultrametric_simplex_builder_top.sv =====
// top level: column list, digit-serial gram check per column pair, row word tracking
// done: clear, unused command, refused append and a check on fewer than two
//   columns strobe done in the cycle after the start transfer; an append passes S_ROWS first
// a check runs read, load, four 4-bit digit steps through the popcount datapath and
//   evaluate for each column pair, up to 120 pairs, and stops at the first failing pair
// one item at a time: start is taken only while busy is low; results cannot be stalled
// reset: column count and row words cleared, dimension 16, column ram left unset
`timescale 1ns / 1ps

module ultrametric_simplex_builder_top
    import usb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       cmd,
    input  logic [15:0]      vertex,
    output logic             done,
    output logic             ultrametric_ok,
    output logic             row_order_ok,
    output logic             overflow,
    output logic [4:0]       column_count,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [DIM_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic [DIM_W-1:0]    dim_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [MAX_COLS-1:0] row_reg  [MAX_DIM];
    logic [MAX_COLS-1:0] row_next [MAX_DIM];
    logic [MAX_DIM-1:0]  vertex_reg, vertex_next;
    logic [COL_AW-1:0]   i_reg, i_next, j_reg, j_next;
    logic [DIGIT_CW-1:0] digit_reg, digit_next;
    logic [MAX_DIM-1:0]  a_sh_reg, a_sh_next, b_sh_reg, b_sh_next, c_sh_reg, c_sh_next;
    logic [GRAM_W-1:0]   g11_reg, g22_reg, g33_reg, g12_reg, g13_reg, g23_reg;
    logic [GRAM_W-1:0]   g11_next, g22_next, g33_next, g12_next, g13_next, g23_next;
    logic                done_reg, done_next;
    logic                um_reg, um_next, ro_reg, ro_next, ov_reg, ov_next;

    logic                ram_we;
    logic [MAX_DIM-1:0]  rdata_a, rdata_b;
    logic [MAX_DIM-1:0]  mask;
    logic [DIM_W-1:0]    deff;
    logic                accept;
    logic                pair_ok, min_unique, last_pair, last_j, rows_ok;
    logic [DIGIT_W-1:0]  da, db, dc;

    assign accept       = start && !busy;
    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = !busy;
    assign done         = done_reg;
    assign ultrametric_ok = um_reg;
    assign row_order_ok = ro_reg;
    assign overflow     = ov_reg;
    assign column_count = count_reg;
    assign mask         = dim_mask(dim_reg);
    assign deff         = eff_dim(dim_reg);

    usb_ram #(
        .WIDTH (MAX_DIM),
        .DEPTH (MAX_COLS)
    ) u_column_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (count_reg[COL_AW-1:0]),
        .wdata   (vertex),
        .raddr_a (i_reg),
        .rdata_a (rdata_a),
        .raddr_b (j_reg),
        .rdata_b (rdata_b)
    );

    assign da = a_sh_reg[DIGIT_W-1:0];
    assign db = b_sh_reg[DIGIT_W-1:0];
    assign dc = c_sh_reg[DIGIT_W-1:0];

    // gram conditions for one pair with the new vertex
    assign min_unique = (g12_reg < g13_reg && g12_reg < g23_reg) ||
                        (g13_reg < g12_reg && g13_reg < g23_reg) ||
                        (g23_reg < g12_reg && g23_reg < g13_reg);
    assign pair_ok = (g11_reg > g12_reg) && (g11_reg > g13_reg) &&
                     (g22_reg > g12_reg) && (g22_reg > g23_reg) &&
                     (g33_reg > g13_reg) && (g33_reg > g23_reg) &&
                     !min_unique &&
                     (g12_reg != '0) && (g13_reg != '0) && (g23_reg != '0);
    assign last_j    = (CNT_W'(j_reg) == count_reg - CNT_W'(1));
    assign last_pair = last_j && (CNT_W'(i_reg) == count_reg - CNT_W'(2));

    always_comb
    begin
        rows_ok = 1'b1;
        for (int k = 0; k < MAX_DIM - 1; k++)
        begin
            if ((k + 1) < deff && row_reg[k] < row_reg[k + 1])
            begin
                rows_ok = 1'b0;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_CHECK:
                        begin
                            if (count_reg >= CNT_W'(2))
                                state_next = S_READ;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_COLS))
                                state_next = S_ROWS;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (digit_reg == DIGIT_CW'(DIGITS - 1))
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (!pair_ok || last_pair)
                    state_next = S_IDLE;
                else
                    state_next = S_READ;
            end
            S_ROWS:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and results
    always_comb
    begin
        count_next  = count_reg;
        row_next    = row_reg;
        vertex_next = vertex_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        digit_next  = digit_reg;
        a_sh_next   = a_sh_reg;
        b_sh_next   = b_sh_reg;
        c_sh_next   = c_sh_reg;
        g11_next    = g11_reg;
        g22_next    = g22_reg;
        g33_next    = g33_reg;
        g12_next    = g12_reg;
        g13_next    = g13_reg;
        g23_next    = g23_reg;
        done_next   = 1'b0;
        um_next     = um_reg;
        ro_next     = ro_reg;
        ov_next     = ov_reg;
        ram_we      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    vertex_next = vertex;
                    um_next     = 1'b0;
                    ro_next     = 1'b0;
                    ov_next     = 1'b0;
                    i_next      = '0;
                    j_next      = COL_AW'(1);
                    case (cmd)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            for (int k = 0; k < MAX_DIM; k++)
                            begin
                                row_next[k] = '0;
                            end
                            done_next = 1'b1;
                        end
                        CMD_CHECK:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                um_next   = 1'b1;
                                done_next = 1'b1;
                            end
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg >= CNT_W'(MAX_COLS))
                            begin
                                ov_next   = 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                for (int k = 0; k < MAX_DIM; k++)
                                begin
                                    if (k < deff)
                                    begin
                                        row_next[k] = {row_reg[k][MAX_COLS-2:0], vertex[k]};
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                digit_next = '0;
            end
            S_LOAD:
            begin
                a_sh_next = rdata_a & mask;
                b_sh_next = rdata_b & mask;
                c_sh_next = vertex_reg & mask;
                g11_next  = '0;
                g22_next  = '0;
                g33_next  = '0;
                g12_next  = '0;
                g13_next  = '0;
                g23_next  = '0;
            end
            S_ACC:
            begin
                g11_next   = g11_reg + GRAM_W'(popcount_digit(da));
                g22_next   = g22_reg + GRAM_W'(popcount_digit(db));
                g33_next   = g33_reg + GRAM_W'(popcount_digit(dc));
                g12_next   = g12_reg + GRAM_W'(popcount_digit(da & db));
                g13_next   = g13_reg + GRAM_W'(popcount_digit(da & dc));
                g23_next   = g23_reg + GRAM_W'(popcount_digit(db & dc));
                a_sh_next  = a_sh_reg >> DIGIT_W;
                b_sh_next  = b_sh_reg >> DIGIT_W;
                c_sh_next  = c_sh_reg >> DIGIT_W;
                digit_next = digit_reg + DIGIT_CW'(1);
            end
            S_EVAL:
            begin
                if (!pair_ok)
                begin
                    um_next   = 1'b0;
                    done_next = 1'b1;
                end
                else if (last_pair)
                begin
                    um_next   = 1'b1;
                    done_next = 1'b1;
                end
                else if (last_j)
                begin
                    i_next = i_reg + COL_AW'(1);
                    j_next = i_reg + COL_AW'(2);
                end
                else
                begin
                    j_next = j_reg + COL_AW'(1);
                end
            end
            S_ROWS:
            begin
                ro_next   = rows_ok;
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dim_reg   <= DIM_W'(MAX_DIM);
            count_reg <= '0;
            done_reg  <= 1'b0;
            for (int k = 0; k < MAX_DIM; k++)
            begin
                row_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            row_reg   <= row_next;
            if (cfg_valid && cfg_ready)
            begin
                dim_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        vertex_reg <= vertex_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        digit_reg  <= digit_next;
        a_sh_reg   <= a_sh_next;
        b_sh_reg   <= b_sh_next;
        c_sh_reg   <= c_sh_next;
        g11_reg    <= g11_next;
        g22_reg    <= g22_next;
        g33_reg    <= g33_next;
        g12_reg    <= g12_next;
        g13_reg    <= g13_next;
        g23_reg    <= g23_next;
        um_reg     <= um_next;
        ro_reg     <= ro_next;
        ov_reg     <= ov_next;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done strobed while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0({ultrametric_ok, row_order_ok, overflow}))
        else $error("more than one result flag set");
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> (column_count == CNT_W'(MAX_COLS)))
        else $error("overflow with list not full");
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done))
        else $error("start transfer produced neither work nor result");
`endif

endmodule
